// ===== design/att_pkg.sv =====
package att_pkg;

  // Component and sum widths: components are -32..31, squares reach 1024,
  // a sum of two squares reaches 2048 and the sum of all three 3072.
  localparam int RAW_W = 8;
  localparam int COMP_W = 6;
  localparam int SQ1_W = 11;
  localparam int N_W = 12;
  localparam int T_W = 12;

  // Angle search: 7 bits cover 0..89, one pipeline stage per bit.
  localparam int ANG_W = 7;
  localparam int ANG_DEPTH = 1 << ANG_W;
  localparam int ANG_MAX = 89;

  // sin^2 thresholds in unsigned fixed point with SQ_FRAC fraction bits.
  localparam int SQ_FRAC = 44;
  localparam int PROD_W = T_W + SQ_FRAC;
  localparam real SQ_SCALE = 17592186044416.0;
  localparam real PI_R = 3.14159265358979323846;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_NO_AXIS = 2'd1,
    ST_UNDEF = 2'd2
  } status_t;

  // What the output stage does with an item.
  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_NO_AXIS = 2'd1,
    KIND_UNDEF = 2'd2,
    KIND_RIGHT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [T_W-1:0] t;
    logic [ANG_W-1:0] ang;
    logic neg;
    kind_t kind;
  } att_item_t;

  typedef logic [SQ_FRAC-1:0] sin_tab_t [ANG_DEPTH];

  localparam logic signed [RAW_W-1:0] ANGLE_RIGHT = 8'sd90;

  // Entry d holds round(sin^2(d degrees) * 2^SQ_FRAC). Entries past the
  // largest angle hold all ones, which no item with a nonzero
  // denominator can reach.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    real s;
    longint v;
    for (int d = 0; d < ANG_DEPTH; d++) begin
      if (d <= ANG_MAX) begin
        s = $sin(PI_R * d / 180.0);
        v = longint'(s * s * SQ_SCALE);
        tab[d] = v[SQ_FRAC-1:0];
      end else begin
        tab[d] = '1;
      end
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_SQ_TAB = build_sin_tab();

endpackage

// ===== design/att_prep.sv =====
module att_prep
  import att_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  axis_t                   axis,
  input  logic signed [RAW_W-1:0] raw_x,
  input  logic signed [RAW_W-1:0] raw_y,
  input  logic signed [RAW_W-1:0] raw_z,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic                    dn_ready,
  output logic                    dn_valid,
  output att_item_t               dn_item
);

  // Divide by four, truncating toward zero.
  function automatic logic signed [COMP_W-1:0] div4(logic signed [RAW_W-1:0] s);
    logic signed [RAW_W-1:0] b;
    logic signed [RAW_W-1:0] q;
    b = s + (s[RAW_W-1] ? 8'sd3 : 8'sd0);
    q = b >>> 2;
    return q[COMP_W-1:0];
  endfunction

  function automatic logic [SQ1_W-1:0] square(logic signed [COMP_W-1:0] c);
    logic [COMP_W-1:0] m;
    logic [2*COMP_W-1:0] p;
    m = c[COMP_W-1] ? COMP_W'(-c) : c;
    p = (2*COMP_W)'(m) * (2*COMP_W)'(m);
    return p[SQ1_W-1:0];
  endfunction

  logic signed [COMP_W-1:0] cx, cy, cz;
  logic [SQ1_W-1:0] sx, sy, sz;
  logic [N_W-1:0] n, den;
  logic [T_W:0] t_full;
  logic neg;
  logic valid_r;
  att_item_t item_r, item_nxt;

  assign cx = div4(raw_x);
  assign cy = div4(raw_y);
  assign cz = div4(raw_z);
  assign sx = square(cx);
  assign sy = square(cy);
  assign sz = square(cz);

  always_comb begin
    case (axis)
      AXIS_X: begin
        n = N_W'(sx);
        den = N_W'(sy) + N_W'(sz);
        neg = cx[COMP_W-1];
      end
      AXIS_Y: begin
        n = N_W'(sy);
        den = N_W'(sx) + N_W'(sz);
        neg = cy[COMP_W-1];
      end
      default: begin
        n = N_W'(sx) + N_W'(sy);
        den = N_W'(sz);
        neg = cz[COMP_W-1];
      end
    endcase
  end

  assign t_full = (T_W+1)'(n) + (T_W+1)'(den);

  always_comb begin
    item_nxt.n = n;
    item_nxt.t = t_full[T_W-1:0];
    item_nxt.ang = '0;
    item_nxt.neg = neg;
    if (axis == AXIS_NONE) begin
      item_nxt.kind = KIND_NO_AXIS;
    end else if (den == '0 && n == '0) begin
      item_nxt.kind = KIND_UNDEF;
    end else if (den == '0) begin
      item_nxt.kind = KIND_RIGHT;
    end else begin
      item_nxt.kind = KIND_SEARCH;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item = item_r;

endmodule

// ===== design/att_srch.sv =====
module att_srch
  import att_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  att_item_t up_item,
  input  logic      dn_ready,
  output logic      dn_valid,
  output att_item_t dn_item
);

  // One bit of the angle: keep the candidate when sin^2 of it does not
  // exceed n / t, tested as n * 2^SQ_FRAC >= t * table entry.
  logic [ANG_W-1:0] cand;
  logic [PROD_W-1:0] lhs, rhs;
  logic hit;
  logic valid_r;
  att_item_t item_r, item_nxt;

  assign cand = up_item.ang | (ANG_W'(1) << BIT);
  assign lhs = {up_item.n, {SQ_FRAC{1'b0}}};
  assign rhs = PROD_W'(up_item.t) * PROD_W'(SIN_SQ_TAB[cand]);
  assign hit = (lhs >= rhs);

  always_comb begin
    item_nxt = up_item;
    if (hit) begin
      item_nxt.ang = cand;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item = item_r;

endmodule

// ===== design/accel_tilt_angle.sv =====
// Tilt angle of a three-axis accelerometer sample.
// Items enter on the in_ channel (in_raw_x, in_raw_y, in_raw_z, signed
// bytes) under in_valid/in_ready; one result per item leaves on the out_
// channel (out_angle_deg in whole degrees, truncated toward zero, and
// out_status) under out_valid/out_ready, in the order the items came in.
// The cfg_ channel writes the axis selection (0 x, 1 y, 2 z, 3 none); it is
// always ready and should only be written while no item is in flight.
// It takes one item per cycle unless out_ready holds the pipeline back. An
// item passes one stage that scales and squares the components, seven
// stages that each resolve one bit of the angle with a 12 by 44 bit
// multiply against a sin^2 threshold table, and one output register that
// applies the sign and the special cases, in that order.
// Every stage carries its own valid bit and accepts a new item whenever
// it is empty or the stage after it moves, so a stalled receiver only
// backs the pipeline up as far as it is full; in_ready drops only once
// every stage holds an item. Nothing is lost or repeated across a stall.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the
// axis selection to none.
module accel_tilt_angle
  import att_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw_x,
  input  logic signed [RAW_W-1:0] in_raw_y,
  input  logic signed [RAW_W-1:0] in_raw_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RAW_W-1:0] out_angle_deg,
  output logic [1:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_axis_select
);

  // Axis selection register.
  axis_t axis_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_NONE;
    end else if (cfg_valid) begin
      axis_r <= axis_t'(cfg_axis_select);
    end
  end

  // Stage 0 is the component stage, stages 1..ANG_W the bit search.
  // rdy[k] is the ready of stage k; rdy[ANG_W+1] belongs to the output
  // register.
  logic      vld [0:ANG_W];
  att_item_t itm [0:ANG_W];
  logic      rdy [0:ANG_W+1];

  att_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .axis     (axis_r),
    .raw_x    (in_raw_x),
    .raw_y    (in_raw_y),
    .raw_z    (in_raw_z),
    .up_valid (in_valid),
    .up_ready (rdy[0]),
    .dn_ready (rdy[1]),
    .dn_valid (vld[0]),
    .dn_item  (itm[0])
  );

  // The most significant angle bit is decided first.
  for (genvar k = 1; k <= ANG_W; k++) begin : g_srch
    att_srch #(
      .BIT (ANG_W - k)
    ) u_srch (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[k-1]),
      .up_ready (rdy[k]),
      .up_item  (itm[k-1]),
      .dn_ready (rdy[k+1]),
      .dn_valid (vld[k]),
      .dn_item  (itm[k])
    );
  end

  assign in_ready = rdy[0];

  // Output register: sign, the vertical case and the status code.
  logic out_valid_r;
  logic signed [RAW_W-1:0] angle_r, angle_nxt;
  status_t status_r, status_nxt;
  logic signed [RAW_W-1:0] mag;
  att_item_t last;

  assign last = itm[ANG_W];
  assign mag = {{(RAW_W-ANG_W){1'b0}}, last.ang};

  always_comb begin
    angle_nxt = '0;
    status_nxt = ST_VALID;
    case (last.kind)
      KIND_SEARCH: angle_nxt = last.neg ? -mag : mag;
      KIND_RIGHT: angle_nxt = last.neg ? -ANGLE_RIGHT : ANGLE_RIGHT;
      KIND_NO_AXIS: status_nxt = ST_NO_AXIS;
      KIND_UNDEF: status_nxt = ST_UNDEF;
      default: status_nxt = ST_VALID;
    endcase
  end

  assign rdy[ANG_W+1] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[ANG_W+1]) begin
      out_valid_r <= vld[ANG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ANG_W+1] && vld[ANG_W]) begin
      angle_r <= angle_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle_deg = angle_r;
  assign out_status = status_r;

`ifndef SYNTHESIS
  // A full pipeline is the only reason to refuse an item, and that needs a
  // held result at the output.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output register was free");

  // Undefined and no-axis results carry a zero angle.
  a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDEF || out_status == ST_NO_AXIS)
      |-> out_angle_deg == 8'sd0)
    else $error("special result with a nonzero angle");

  // Valid angles stay within plus or minus ninety degrees.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_VALID
      |-> out_angle_deg <= ANGLE_RIGHT && out_angle_deg >= -ANGLE_RIGHT)
    else $error("angle out of range");

  // With no axis chosen for the whole trip through the pipe, every result
  // says so.
  a_no_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $rose(out_valid) && axis_r == AXIS_NONE
      && $past(axis_r == AXIS_NONE, 9) && $past(rst_n, 9)
      && $past(axis_r == AXIS_NONE, 1)
      |-> out_status == ST_NO_AXIS)
    else $error("result computed for an axis while none was chosen");
`endif

endmodule
